FILE: design/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
package pfe_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_DIVZERO   = 2'd3;

  typedef enum logic [2:0] {
    SK_DIGIT,
    SK_ADD,
    SK_SUB,
    SK_MUL,
    SK_DIV,
    SK_OTHER
  } sym_kind_t;

  typedef enum logic [2:0] {
    TOP_HOLD,
    TOP_DIGIT,
    TOP_ADDSUB,
    TOP_MUL,
    TOP_DIV,
    TOP_ZERO,
    TOP_RD
  } top_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC1,
    CNT_DEC2
  } cnt_op_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_LHS,
    RD_BELOW
  } rd_sel_t;

  typedef struct packed {
    logic       latch;
    top_sel_t   top_sel;
    cnt_op_t    cnt_op;
    rd_sel_t    rd_sel;
    logic       div_start;
    logic       err_set;
    logic [1:0] err_code;
    logic       emit;
  } pfe_cmd_t;

  typedef struct packed {
    sym_kind_t kind;
    logic      last;
    logic      full;
    logic      lt2;
    logic      ge3;
    logic      rhs_zero;
    logic      div_done;
    logic      out_busy;
  } pfe_stat_t;

endpackage

FILE: design/pfe_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module pfe_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rem_r, quo_r[31]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = 32'd0;
      quo_nxt  = dividend[31] ? 32'd0 - dividend : dividend;
      den_nxt  = divisor[31] ? 32'd0 - divisor : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? 32'd0 - quo_r : quo_r;

endmodule

FILE: design/pfe_dpath.sv
// Datapath: operand stack memory, top-of-stack register, arithmetic and result register.
module pfe_dpath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfe_pkg::pfe_cmd_t cmd,
  output pfe_pkg::pfe_stat_t stat,
  input  logic [7:0]        in_symbol,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_value,
  output logic [1:0]        out_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0]   mem [STACK_DEPTH];
  logic [7:0]    sym_r;
  logic          last_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [31:0]   tos_r, tos_nxt;
  logic [31:0]   rd_data_r;
  logic [31:0]   prod_r;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_value_r;
  logic [1:0]    out_status_r;
  logic [CW-1:0] cnt_m1, cnt_m2, cnt_m3;
  logic [AW-1:0] rd_addr;
  logic [31:0]   addsub;
  logic [31:0]   quotient;
  logic          div_done;
  logic          out_busy;
  pfe_pkg::sym_kind_t kind;

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_data_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);
  assign cnt_m3 = count_r - CW'(3);

  always_comb begin
    if (sym_r >= pfe_pkg::CH_ZERO && sym_r <= pfe_pkg::CH_NINE) begin
      kind = pfe_pkg::SK_DIGIT;
    end else begin
      unique case (sym_r)
        pfe_pkg::CH_PLUS:  kind = pfe_pkg::SK_ADD;
        pfe_pkg::CH_MINUS: kind = pfe_pkg::SK_SUB;
        pfe_pkg::CH_STAR:  kind = pfe_pkg::SK_MUL;
        pfe_pkg::CH_SLASH: kind = pfe_pkg::SK_DIV;
        default:           kind = pfe_pkg::SK_OTHER;
      endcase
    end
  end

  // rd_data_r holds the left operand, tos_r the right one
  assign addsub = (kind == pfe_pkg::SK_SUB) ? rd_data_r - tos_r : rd_data_r + tos_r;
  assign rd_addr = (cmd.rd_sel == pfe_pkg::RD_BELOW) ? cnt_m3[AW-1:0] : cnt_m2[AW-1:0];
  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    tos_nxt = tos_r;
    case (cmd.top_sel)
      pfe_pkg::TOP_DIGIT:  tos_nxt = {28'd0, sym_r[3:0]};
      pfe_pkg::TOP_ADDSUB: tos_nxt = addsub;
      pfe_pkg::TOP_MUL:    tos_nxt = prod_r;
      pfe_pkg::TOP_DIV:    tos_nxt = quotient;
      pfe_pkg::TOP_ZERO:   tos_nxt = 32'd0;
      pfe_pkg::TOP_RD:     tos_nxt = rd_data_r;
      default:             tos_nxt = tos_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd.cnt_op)
      pfe_pkg::CNT_INC:  count_nxt = count_r + CW'(1);
      pfe_pkg::CNT_DEC1: count_nxt = cnt_m1;
      pfe_pkg::CNT_DEC2: count_nxt = cnt_m2;
      default:           count_nxt = count_r;
    endcase
    err_nxt = err_r;
    if (cmd.err_set && err_r == pfe_pkg::ERR_NONE) begin
      err_nxt = cmd.err_code;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit) begin
      count_nxt     = '0;
      err_nxt       = pfe_pkg::ERR_NONE;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= pfe_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.latch) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    tos_r  <= tos_nxt;
    prod_r <= rd_data_r * tos_r;
    if (cmd.emit) begin
      out_value_r  <= (count_r == '0) ? 32'd0 : tos_r;
      out_status_r <= (err_r != pfe_pkg::ERR_NONE) ? err_r :
                      (count_r == '0) ? pfe_pkg::ERR_UNDERFLOW : pfe_pkg::ERR_NONE;
    end
  end

  // spill the old top into memory on a push
  always_ff @(posedge clk) begin
    if (cmd.top_sel == pfe_pkg::TOP_DIGIT && count_r != '0) begin
      mem[cnt_m1[AW-1:0]] <= tos_r;
    end
    if (cmd.rd_sel != pfe_pkg::RD_NONE) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    stat.kind     = kind;
    stat.last     = last_r;
    stat.full     = count_r >= CW'(STACK_DEPTH);
    stat.lt2      = count_r < CW'(2);
    stat.ge3      = count_r >= CW'(3);
    stat.rhs_zero = tos_r == 32'd0;
    stat.div_done = div_done;
    stat.out_busy = out_busy;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_busy)
    else $error("result overwritten while waiting");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == '0 && err_r == pfe_pkg::ERR_NONE && out_valid_r))
    else $error("stack not emptied after result");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == pfe_pkg::CNT_INC && !cmd.emit) |=>
      count_r == $past(count_r) + CW'(1))
    else $error("push did not grow the stack");

endmodule

FILE: design/pfe_ctrl.sv
// Controller: sequences the stack, arithmetic and result steps for one symbol.
module pfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfe_pkg::pfe_stat_t stat,
  output pfe_pkg::pfe_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LHS,
    ST_MUL,
    ST_DIV,
    ST_POP,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.top_sel   = pfe_pkg::TOP_HOLD;
    cmd.cnt_op    = pfe_pkg::CNT_HOLD;
    cmd.rd_sel    = pfe_pkg::RD_NONE;
    cmd.err_code  = pfe_pkg::ERR_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.kind == pfe_pkg::SK_DIGIT) begin
          if (stat.full) begin
            cmd.err_set  = 1'b1;
            cmd.err_code = pfe_pkg::ERR_OVERFLOW;
          end else begin
            cmd.top_sel = pfe_pkg::TOP_DIGIT;
            cmd.cnt_op  = pfe_pkg::CNT_INC;
          end
          state_nxt = ST_FIN;
        end else if (stat.lt2) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = pfe_pkg::ERR_UNDERFLOW;
          state_nxt    = ST_FIN;
        end else begin
          cmd.rd_sel = pfe_pkg::RD_LHS;
          state_nxt  = ST_LHS;
        end
      end
      ST_LHS: begin
        case (stat.kind)
          pfe_pkg::SK_ADD, pfe_pkg::SK_SUB: begin
            cmd.top_sel = pfe_pkg::TOP_ADDSUB;
            cmd.cnt_op  = pfe_pkg::CNT_DEC1;
            state_nxt   = ST_FIN;
          end
          pfe_pkg::SK_MUL: state_nxt = ST_MUL;
          pfe_pkg::SK_DIV: begin
            if (stat.rhs_zero) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = pfe_pkg::ERR_DIVZERO;
              cmd.top_sel  = pfe_pkg::TOP_ZERO;
              cmd.cnt_op   = pfe_pkg::CNT_DEC1;
              state_nxt    = ST_FIN;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
          default: begin
            // drop both operands; reload the top from below them when a third one exists
            cmd.cnt_op = pfe_pkg::CNT_DEC2;
            if (stat.ge3) begin
              cmd.rd_sel = pfe_pkg::RD_BELOW;
              state_nxt  = ST_POP;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        endcase
      end
      ST_MUL: begin
        cmd.top_sel = pfe_pkg::TOP_MUL;
        cmd.cnt_op  = pfe_pkg::CNT_DEC1;
        state_nxt   = ST_FIN;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.top_sel = pfe_pkg::TOP_DIV;
          cmd.cnt_op  = pfe_pkg::CNT_DEC1;
          state_nxt   = ST_FIN;
        end
      end
      ST_POP: begin
        cmd.top_sel = pfe_pkg::TOP_RD;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.last) begin
          state_nxt = ST_IDLE;
        end else if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator stream block.
// One symbol beat at a time: every symbol passes IDLE, EXEC and FIN; an operator
// with enough operands adds LHS, then MUL for *, DIV for / with a nonzero divisor
// (waiting on the 32-step iterative divider), or POP for any other character when a
// third operand reloads the top. The result beat is registered in the final symbol's
// FIN step; it holds while the previous result still waits in the output register.
// Synchronous active-low reset empties the stack, clears the error and drops out_tvalid;
// stack memory contents are not cleared.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // last_symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [33:32] status, [39:34] zero
);

  pfe_pkg::pfe_cmd_t  cmd;
  pfe_pkg::pfe_stat_t stat;
  logic [31:0]        value;
  logic [1:0]         status;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfe_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_symbol  (in_tdata),
    .in_last    (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (value),
    .out_status (status)
  );

  assign out_tdata = {6'd0, status, value};

endmodule
